FILE: hdl/pncr_pkg.sv
// ----------------------------------------------------------------------------
// pncr_pkg
// Types, codes and distance helpers shared by the palette remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package pncr_pkg;

    localparam int CHAN_W = 8;
    localparam int DIST_W = 18;  // 3 * 255^2 fits in 18 bits

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic              func;
        logic [7:0]        entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] new_red;
        logic [CHAN_W-1:0] new_green;
        logic [CHAN_W-1:0] new_blue;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              skipped;
        logic              remapped;
    } t_pix_out;

    // Word carried from cell to cell: the item itself plus the running best match.
    typedef struct packed {
        logic              func;
        logic [7:0]        entry_index;
        t_rgb              pix;
        logic [CHAN_W-1:0] alpha;
        t_rgb              new_pix;
        logic              skip;
        logic [DIST_W-1:0] min_dist;
        t_rgb              best_old;
        t_rgb              best_new;
    } t_chain_word;

    function automatic logic [15:0] sq_diff(input logic [CHAN_W-1:0] a,
                                            input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    function automatic logic [DIST_W-1:0] colour_dist(input t_rgb a, input t_rgb b);
        return DIST_W'(sq_diff(a.red, b.red)) + DIST_W'(sq_diff(a.green, b.green))
             + DIST_W'(sq_diff(a.blue, b.blue));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pncr_cell.sv
// ----------------------------------------------------------------------------
// pncr_cell
// One palette entry pair and one compare step of the search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pncr_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_advance,
    input  wire                    i_valid,
    input  wire pncr_pkg::t_chain_word i_word,
    output logic                   o_valid,
    output pncr_pkg::t_chain_word  o_word
);
    import pncr_pkg::*;

    t_rgb              r_old;
    t_rgb              r_new;
    logic              r_valid;
    t_chain_word       r_word;
    t_chain_word       n_word;
    logic [DIST_W-1:0] w_dist;
    logic              w_hit;

    assign w_hit  = i_valid && (i_word.func == FUNC_LOAD)
                 && (i_word.entry_index == 8'(CELL_INDEX));
    assign w_dist = colour_dist(r_old, i_word.pix);

    always_comb begin
        n_word = i_word;
        // strict less-than: an earlier entry keeps a tie
        if (i_word.func == FUNC_PIXEL && w_dist < i_word.min_dist) begin
            n_word.min_dist = w_dist;
            n_word.best_old = r_old;
            n_word.best_new = r_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_hit) begin
            r_old <= i_word.pix;
            r_new <= i_word.new_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

FILE: hdl/palette_nearest_colour_remap.sv
// ----------------------------------------------------------------------------
// palette_nearest_colour_remap
// Nearest-colour search over an old palette with remap to a new palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on i_in_valid / o_in_ready with a t_pix_in payload.
//   A load word (func = FUNC_LOAD) writes one old/new palette entry pair;
//   it gives no output word. A pixel word (func = FUNC_PIXEL) gives one
//   output word on o_out_valid / i_out_ready.
//   Every word walks a chain of PALETTE_ENTRIES cells, one cell per cycle
//   unless stalled. Each cell holds one entry pair, scores the pixel against
//   its old color and keeps the best match so far. Loads travel the same
//   chain, so each pixel sees exactly the palette written before it.
//   A pixel passes all cell registers, then the output register.
//   Throughput: one word per cycle unless stalled; one compare step per cell.
//   Stall: when the output register holds a word the receiver has not taken,
//   the whole chain holds and o_in_ready drops.
//   Reset clears all valid bits and sets alpha_present to 1; palette
//   contents are undefined until loaded. i_cfg_we writes alpha_present;
//   the user must write it only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_nearest_colour_remap #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire pncr_pkg::t_pix_in i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output pncr_pkg::t_pix_out   o_out_data,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_wdata
);
    import pncr_pkg::*;

    logic        w_advance;
    logic        w_valid [0:PALETTE_ENTRIES];
    t_chain_word w_word  [0:PALETTE_ENTRIES];

    logic        r_alpha_present;
    logic        r_out_valid;
    t_pix_out    r_out;
    t_pix_out    n_out;

    // Move the chain whenever the output slot is free or being drained.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_present <= 1'b1;
        end else if (i_cfg_we) begin
            r_alpha_present <= i_cfg_wdata;
        end
    end

    // Build the head word; the best match starts at the top distance so
    // entry zero always wins the first compare.
    assign w_valid[0] = i_in_valid;
    always_comb begin
        w_word[0].func        = i_in_data.func;
        w_word[0].entry_index = i_in_data.entry_index;
        w_word[0].pix         = '{i_in_data.red, i_in_data.green, i_in_data.blue};
        w_word[0].alpha       = i_in_data.alpha;
        w_word[0].new_pix     = '{i_in_data.new_red, i_in_data.new_green,
                                  i_in_data.new_blue};
        w_word[0].skip        = r_alpha_present && (i_in_data.alpha == '0);
        w_word[0].min_dist    = DIST_MAX;
        w_word[0].best_old    = '0;
        w_word[0].best_new    = '0;
    end

    for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
        pncr_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_valid   (w_valid[g]),
            .i_word    (w_word[g]),
            .o_valid   (w_valid[g+1]),
            .o_word    (w_word[g+1])
        );
    end

    // Resolve the chain tail: skip transparent pixels, otherwise replace the
    // color when the winning old entry differs from its new entry.
    always_comb begin
        n_out.out_red   = w_word[PALETTE_ENTRIES].pix.red;
        n_out.out_green = w_word[PALETTE_ENTRIES].pix.green;
        n_out.out_blue  = w_word[PALETTE_ENTRIES].pix.blue;
        n_out.out_alpha = w_word[PALETTE_ENTRIES].alpha;
        n_out.skipped   = w_word[PALETTE_ENTRIES].skip;
        n_out.remapped  = 1'b0;
        if (!w_word[PALETTE_ENTRIES].skip
            && w_word[PALETTE_ENTRIES].best_old != w_word[PALETTE_ENTRIES].best_new) begin
            n_out.out_red   = w_word[PALETTE_ENTRIES].best_new.red;
            n_out.out_green = w_word[PALETTE_ENTRIES].best_new.green;
            n_out.out_blue  = w_word[PALETTE_ENTRIES].best_new.blue;
            n_out.remapped  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            // drop load words at the tail
            r_out_valid <= w_valid[PALETTE_ENTRIES]
                        && (w_word[PALETTE_ENTRIES].func == FUNC_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
